### src/utlf_pkg.sv
// utlf_pkg: widths, constants and register indexes for the tank level frame parser
// depends on nothing; used by ultrasonic_tank_level_frame
package utlf_pkg;

    localparam int VOL_W      = 20;                 // litre volume width
    localparam int DEPTH_W    = 10;                 // depth and height width in cm
    localparam int DIST_W     = 16;                 // distance in mm
    localparam int DIV_W      = VOL_W + DEPTH_W;    // widest dividend, capacity times depth
    localparam int PCT_W      = 7;                  // fill percent width
    localparam int PCT_PROD_W = 17;                 // depth times 100 fits here
    localparam int CNT_W      = $clog2(DIV_W + 1);  // divider step counter
    localparam int CFG_IDX_W  = 2;

    localparam logic [7:0] HEADER_BYTE = 8'hFF;

    // floor(x / 10) == (x * 52429) >> 19 for every 16-bit x
    localparam int RECIP_W     = 17;
    localparam logic [RECIP_W-1:0] RECIP_TEN = 17'd52429;
    localparam int RECIP_SHIFT = 19;
    localparam int TENTH_W     = DIST_W - 3;        // 65535 / 10 fits in 13 bits

    localparam logic [PCT_W-1:0] PERCENT_SCALE = 7'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_DEPTH  = 2'd0,
        REG_OFFSET     = 2'd1,
        REG_CAPACITY   = 2'd2,
        REG_STORAGE    = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        POS_HUNT   = 2'd0,
        POS_HIGH   = 2'd1,
        POS_LOW    = 2'd2,
        POS_CHECK  = 2'd3
    } frame_pos_t;

endpackage

### src/ultrasonic_tank_level_frame.sv
// ultrasonic_tank_level_frame: sensor frame parser with depth and volume math
// depends on utlf_pkg; one shared restoring divider does both divisions by max depth
//
// usage
//   input channel: one received sensor byte per item on rx_byte, in_valid / in_stall.
//   the parser hunts for header 0xFF, then takes distance high, distance low and the
//   checksum byte. header and distance bytes are taken without stalling the input.
//   the checksum byte starts the math: distance/10 by reciprocal multiply, clamp,
//   capacity*depth, then a one-bit-per-cycle divide by max depth (30 steps) and
//   depth*100 divided the same way (17 steps); zero max depth skips both divides.
//   a good frame's result reaches S_DONE after the divides; a bad checksum goes
//   straight to S_DONE with status 1 and zero values; S_DONE loads the output register.
//   in_stall is high while the math runs and while S_DONE waits; bytes inside a frame
//   are taken even while a previous result still waits on the output.
//   output channel: out_valid / out_stall with one output register; while the receiver
//   stalls, the result holds and the block waits in its final state.
//   configuration: cfg_valid / cfg_ready with cfg_index 0..3 (max depth, offset,
//   capacity, storage cap); cfg_ready is always high, write only while idle.
//   reset: registers take their defaults (200, 0, 1000, 500), the parser hunts for a
//   header and no result is pending.
module ultrasonic_tank_level_frame
    import utlf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           rx_byte,

    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 status,
    output logic [DEPTH_W-1:0]   depth_cm,
    output logic [VOL_W-1:0]     total_liters,
    output logic [PCT_W-1:0]     fill_percent,
    output logic [VOL_W-1:0]     storage_liters,
    output logic [VOL_W-1:0]     retention_liters,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [VOL_W-1:0]     cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RECIP,
        S_CLAMP,
        S_MUL,
        S_DIV_TOTAL,
        S_LOAD_PCT,
        S_DIV_PCT,
        S_DONE
    } state_t;

    // configuration registers
    logic [DEPTH_W-1:0] max_depth_reg;
    logic [DEPTH_W-1:0] offset_reg;
    logic [VOL_W-1:0]   capacity_reg;
    logic [VOL_W-1:0]   storage_cap_reg;

    // frame parser
    frame_pos_t  pos_reg;
    logic [7:0]  dist_hi_reg;
    logic [7:0]  dist_lo_reg;
    logic [7:0]  sum_reg;

    // sequencer and datapath
    state_t             state_reg;
    logic               bad_reg;
    logic [TENTH_W-1:0] tenth_reg;
    logic [DEPTH_W-1:0] depth_reg;
    logic [VOL_W-1:0]   total_reg;
    logic [PCT_W-1:0]   pct_reg;

    // shared divider: dividend shifts out at the top, quotient bits shift in at the bottom
    logic [DIV_W-1:0]   dvd_reg;
    logic [DEPTH_W-1:0] rem_reg;
    logic [CNT_W-1:0]   cnt_reg;

    // output register
    logic               out_valid_reg;
    logic               status_reg;
    logic [DEPTH_W-1:0] depth_out_reg;
    logic [VOL_W-1:0]   total_out_reg;
    logic [PCT_W-1:0]   pct_out_reg;
    logic [VOL_W-1:0]   stor_out_reg;
    logic [VOL_W-1:0]   ret_out_reg;

    logic                      in_take;
    logic                      out_free;
    logic [7:0]                sum_next;
    logic [DIST_W+RECIP_W-1:0] recip_prod;
    logic [DEPTH_W:0]          depth_sum;
    logic [DEPTH_W:0]          depth_diff;
    logic [DEPTH_W-1:0]        depth_next;
    logic [DEPTH_W+1:0]        trial;
    logic [DEPTH_W-1:0]        rem_next;
    logic [DIV_W-1:0]          dvd_next;
    logic [DIV_W-1:0]          cap_prod;
    logic [PCT_PROD_W-1:0]     pct_prod;
    logic [VOL_W-1:0]          stor_next;
    logic [VOL_W-1:0]          ret_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;
    assign sum_next  = sum_reg + rx_byte;

    // distance in cm by reciprocal multiply
    assign recip_prod = {dist_hi_reg, dist_lo_reg} * RECIP_TEN;

    // depth = max + offset - distance/10, clamped to 0..max
    always_comb
    begin
        depth_sum  = {1'b0, max_depth_reg} + {1'b0, offset_reg};
        depth_diff = depth_sum - tenth_reg[DEPTH_W:0];
        if (tenth_reg > {{(TENTH_W-DEPTH_W-1){1'b0}}, depth_sum})
            depth_next = '0;
        else if (depth_diff > {1'b0, max_depth_reg})
            depth_next = max_depth_reg;
        else
            depth_next = depth_diff[DEPTH_W-1:0];
    end

    // one restoring divide step by max depth
    always_comb
    begin
        trial = {rem_reg, dvd_reg[DIV_W-1]} - {2'b00, max_depth_reg};
        if (!trial[DEPTH_W+1])
        begin
            rem_next = trial[DEPTH_W-1:0];
            dvd_next = {dvd_reg[DIV_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = {rem_reg[DEPTH_W-2:0], dvd_reg[DIV_W-1]};
            dvd_next = {dvd_reg[DIV_W-2:0], 1'b0};
        end
    end

    assign cap_prod = capacity_reg * depth_reg;
    assign pct_prod = depth_reg * PERCENT_SCALE;

    // storage is capped, the excess goes to retention
    always_comb
    begin
        if (total_reg >= storage_cap_reg)
        begin
            stor_next = storage_cap_reg;
            ret_next  = total_reg - storage_cap_reg;
        end
        else
        begin
            stor_next = total_reg;
            ret_next  = '0;
        end
    end

    // configuration writes, values masked to register width
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_depth_reg   <= DEPTH_W'(200);
            offset_reg      <= '0;
            capacity_reg    <= VOL_W'(1000);
            storage_cap_reg <= VOL_W'(500);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MAX_DEPTH: max_depth_reg   <= cfg_data[DEPTH_W-1:0];
                REG_OFFSET:    offset_reg      <= cfg_data[DEPTH_W-1:0];
                REG_CAPACITY:  capacity_reg    <= cfg_data;
                REG_STORAGE:   storage_cap_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // sequencer, parser and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= POS_HUNT;
            dist_hi_reg   <= '0;
            dist_lo_reg   <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
            bad_reg       <= 1'b0;
            tenth_reg     <= '0;
            depth_reg     <= '0;
            total_reg     <= '0;
            pct_reg       <= '0;
            dvd_reg       <= '0;
            rem_reg       <= '0;
            cnt_reg       <= '0;
            status_reg    <= 1'b0;
            depth_out_reg <= '0;
            total_out_reg <= '0;
            pct_out_reg   <= '0;
            stor_out_reg  <= '0;
            ret_out_reg   <= '0;
        end
        else
        begin
            // a finishing item refills the register itself
            if (out_valid_reg && !out_stall && state_reg != S_DONE)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_take)
                    begin
                        case (pos_reg)
                            POS_HUNT:
                            begin
                                if (rx_byte == HEADER_BYTE)
                                begin
                                    sum_reg <= HEADER_BYTE;
                                    pos_reg <= POS_HIGH;
                                end
                            end
                            POS_HIGH:
                            begin
                                dist_hi_reg <= rx_byte;
                                sum_reg     <= sum_next;
                                pos_reg     <= POS_LOW;
                            end
                            POS_LOW:
                            begin
                                dist_lo_reg <= rx_byte;
                                sum_reg     <= sum_next;
                                pos_reg     <= POS_CHECK;
                            end
                            default:
                            begin
                                pos_reg <= POS_HUNT;
                                if (rx_byte != sum_reg)
                                begin
                                    bad_reg   <= 1'b1;
                                    state_reg <= S_DONE;
                                end
                                else
                                begin
                                    bad_reg   <= 1'b0;
                                    state_reg <= S_RECIP;
                                end
                            end
                        endcase
                    end
                end
                S_RECIP:
                begin
                    tenth_reg <= recip_prod[RECIP_SHIFT +: TENTH_W];
                    state_reg <= S_CLAMP;
                end
                S_CLAMP:
                begin
                    depth_reg <= depth_next;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    // zero max depth means zero depth and zero volumes
                    if (max_depth_reg == '0)
                    begin
                        total_reg <= '0;
                        pct_reg   <= '0;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        dvd_reg   <= cap_prod;
                        rem_reg   <= '0;
                        cnt_reg   <= CNT_W'(DIV_W);
                        state_reg <= S_DIV_TOTAL;
                    end
                end
                S_DIV_TOTAL:
                begin
                    dvd_reg <= dvd_next;
                    rem_reg <= rem_next;
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == CNT_W'(1))
                    begin
                        total_reg <= dvd_next[VOL_W-1:0];
                        state_reg <= S_LOAD_PCT;
                    end
                end
                S_LOAD_PCT:
                begin
                    // only the top PCT_PROD_W dividend bits carry data
                    dvd_reg   <= {pct_prod, {(DIV_W-PCT_PROD_W){1'b0}}};
                    rem_reg   <= '0;
                    cnt_reg   <= CNT_W'(PCT_PROD_W);
                    state_reg <= S_DIV_PCT;
                end
                S_DIV_PCT:
                begin
                    dvd_reg <= dvd_next;
                    rem_reg <= rem_next;
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == CNT_W'(1))
                    begin
                        pct_reg   <= dvd_next[PCT_W-1:0];
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        status_reg    <= bad_reg;
                        if (bad_reg)
                        begin
                            depth_out_reg <= '0;
                            total_out_reg <= '0;
                            pct_out_reg   <= '0;
                            stor_out_reg  <= '0;
                            ret_out_reg   <= '0;
                        end
                        else
                        begin
                            depth_out_reg <= depth_reg;
                            total_out_reg <= total_reg;
                            pct_out_reg   <= pct_reg;
                            stor_out_reg  <= stor_next;
                            ret_out_reg   <= ret_next;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid        = out_valid_reg;
    assign status           = status_reg;
    assign depth_cm         = depth_out_reg;
    assign total_liters     = total_out_reg;
    assign fill_percent     = pct_out_reg;
    assign storage_liters   = stor_out_reg;
    assign retention_liters = ret_out_reg;

endmodule

### verif/tb_ultrasonic_tank_level_frame.sv
// tb_ultrasonic_tank_level_frame: self-checking bench for the ultrasonic tank level frame parser
// streams sensor bytes and register writes, predicts each reading and checks every result item
// depends on utlf_pkg and ultrasonic_tank_level_frame
module tb_ultrasonic_tank_level_frame
    import utlf_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MM_PER_CM      = 10;
    localparam int HOLD_CYCLES    = 300;    // long receiver hold-off, fills the block
    localparam int DRAIN_CYCLES   = 80;     // settle time after the last owed reading
    localparam int WATCHDOG_LIMIT = 3000;   // cycles with no handshake at all
    localparam int MAX_REPORTS    = 10;

    // one tank reading as the block reports it
    typedef struct packed {
        logic               status;
        logic [DEPTH_W-1:0] depth;
        logic [VOL_W-1:0]   total;
        logic [PCT_W-1:0]   fill;
        logic [VOL_W-1:0]   storage;
        logic [VOL_W-1:0]   retention;
    } level_reading_t;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // every block input starts at a known value
    logic                 in_valid  = 1'b0;
    logic [7:0]           rx_byte   = '0;
    logic                 out_stall = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [VOL_W-1:0]     cfg_data  = '0;

    logic                 in_stall;
    logic                 out_valid;
    logic                 status;
    logic [DEPTH_W-1:0]   depth_cm;
    logic [VOL_W-1:0]     total_liters;
    logic [PCT_W-1:0]     fill_percent;
    logic [VOL_W-1:0]     storage_liters;
    logic [VOL_W-1:0]     retention_liters;
    logic                 cfg_ready;

    // byte stream waiting to be offered, and readings still owed by the block
    logic [7:0]     pending_bytes[$];
    level_reading_t level_q[$];

    // shadow of the tank registers, reset values
    logic [DEPTH_W-1:0] max_depth   = 10'd200;
    logic [DEPTH_W-1:0] offset      = 10'd0;
    logic [VOL_W-1:0]   capacity    = 20'd1000;
    logic [VOL_W-1:0]   storage_cap = 20'd500;

    // shadow of the frame parser
    frame_pos_t frame_pos = POS_HUNT;
    logic [7:0] dist_hi   = '0;
    logic [7:0] dist_lo   = '0;
    logic [7:0] run_sum   = '0;

    // idling control
    bit idle_on   = 1'b1;   // random bursts on both sides; off for the closing phase
    bit hold_go   = 1'b0;   // starts the one long receiver hold-off
    bit long_hold = 1'b0;
    int send_gap  = 0;
    int recv_gap  = 0;

    // bookkeeping
    int bytes_taken = 0;
    int good_frames = 0;
    int bad_frames  = 0;
    int readings    = 0;
    int cfg_writes  = 0;
    int errors      = 0;
    int quiet       = 0;

    level_reading_t seen;
    level_reading_t wanted;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    ultrasonic_tank_level_frame dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .rx_byte          (rx_byte),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .status           (status),
        .depth_cm         (depth_cm),
        .total_liters     (total_liters),
        .fill_percent     (fill_percent),
        .storage_liters   (storage_liters),
        .retention_liters (retention_liters),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    // depth and volumes for a good frame under the current register settings
    function automatic level_reading_t compute_level(logic [DIST_W-1:0] dist_mm);
        level_reading_t r;
        int depth;
        longint unsigned total;
        longint unsigned pct;
        r = '0;
        depth = int'(max_depth) + int'(offset) - int'(dist_mm / MM_PER_CM);
        // clamp to the physical tank, empty to full
        if (depth < 0)
            depth = 0;
        else if (depth > int'(max_depth))
            depth = int'(max_depth);
        r.depth = DEPTH_W'(depth);
        // zero max depth leaves every volume at zero
        if (max_depth != 0)
        begin
            total = (64'(capacity) * 64'(depth)) / 64'(max_depth);
            pct   = (64'(depth) * 64'(PERCENT_SCALE)) / 64'(max_depth);
            r.total     = VOL_W'(total);
            r.fill      = PCT_W'(pct);
            r.storage   = (total >= 64'(storage_cap)) ? storage_cap : VOL_W'(total);
            r.retention = (total > 64'(storage_cap)) ? VOL_W'(total - 64'(storage_cap)) : '0;
        end
        return r;
    endfunction

    // advance the parser shadow by one accepted byte; the checksum byte owes a reading
    function automatic void take_byte(logic [7:0] b);
        level_reading_t r;
        r = '0;
        case (frame_pos)
            POS_HUNT:
            begin
                // anything but a header is dropped while hunting
                if (b == HEADER_BYTE)
                begin
                    run_sum   = HEADER_BYTE;
                    frame_pos = POS_HIGH;
                end
            end
            POS_HIGH:
            begin
                dist_hi   = b;
                run_sum   = run_sum + b;
                frame_pos = POS_LOW;
            end
            POS_LOW:
            begin
                dist_lo   = b;
                run_sum   = run_sum + b;
                frame_pos = POS_CHECK;
            end
            default:
            begin
                frame_pos = POS_HUNT;
                if (b != run_sum)
                begin
                    // bad checksum: status only, every value zero
                    r.status = 1'b1;
                    bad_frames++;
                end
                else
                begin
                    r = compute_level({dist_hi, dist_lo});
                    good_frames++;
                end
                level_q.push_back(r);
            end
        endcase
    endfunction

    // queue one sensor frame; a corrupt frame gets a wrong checksum byte
    task automatic push_frame(logic [DIST_W-1:0] dist_mm, bit corrupt);
        logic [7:0] sum;
        sum = HEADER_BYTE + dist_mm[15:8] + dist_mm[7:0];
        if (corrupt)
            sum = sum ^ 8'($urandom_range(1, 255));
        pending_bytes.push_back(HEADER_BYTE);
        pending_bytes.push_back(dist_mm[15:8]);
        pending_bytes.push_back(dist_mm[7:0]);
        pending_bytes.push_back(sum);
    endtask

    // mostly well-formed frames near the interesting depth range, some line noise,
    // some wrong checksums and some fully random distances
    task automatic add_random_frame();
        int span;
        int d;
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 3))
                pending_bytes.push_back(8'($urandom_range(0, 254)));
        end
        span = int'(max_depth) + int'(offset);
        case ($urandom_range(0, 9))
            0:       d = 0;
            1:       d = 65535;
            2, 3:    d = $urandom_range(0, 65535);
            default: d = (span - int'($urandom_range(0, span))) * MM_PER_CM
                         + int'($urandom_range(0, MM_PER_CM - 1));
        endcase
        push_frame(DIST_W'(d), $urandom_range(0, 7) == 0);
    endtask

    // register write over the config channel, shadow updated on the handshake
    task automatic write_reg(cfg_index_t idx, logic [VOL_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        // depth registers keep only their low bits
        case (idx)
            REG_MAX_DEPTH: max_depth   = data[DEPTH_W-1:0];
            REG_OFFSET:    offset      = data[DEPTH_W-1:0];
            REG_CAPACITY:  capacity    = data;
            default:       storage_cap = data;
        endcase
        cfg_writes++;
    endtask

    task automatic set_config(logic [VOL_W-1:0] depth_w, logic [VOL_W-1:0] offset_w,
                              logic [VOL_W-1:0] cap_w, logic [VOL_W-1:0] stor_w);
        write_reg(REG_MAX_DEPTH, depth_w);
        write_reg(REG_OFFSET, offset_w);
        write_reg(REG_CAPACITY, cap_w);
        write_reg(REG_STORAGE, stor_w);
    endtask

    // random settings with the extremes mixed in; upper bits of the depth writes are junk
    task automatic random_config();
        logic [DEPTH_W-1:0] depth_v;
        logic [VOL_W-1:0]   cap_v;
        logic [VOL_W-1:0]   stor_v;
        case ($urandom_range(0, 5))
            0:       depth_v = 10'd1;
            1:       depth_v = 10'd1023;
            default: depth_v = 10'($urandom_range(1, 1023));
        endcase
        cap_v = ($urandom_range(0, 4) == 0) ? 20'hFFFFF : 20'($urandom_range(0, 20'hFFFFF));
        case ($urandom_range(0, 5))
            0:       stor_v = '0;
            1:       stor_v = 20'hFFFFF;
            default: stor_v = 20'($urandom_range(0, cap_v));
        endcase
        set_config({10'($urandom), depth_v}, {10'($urandom), 10'($urandom_range(0, 1023))},
                   cap_v, stor_v);
    endtask

    // sender pauses until every owed reading is in, then lets the block settle
    task automatic wait_drained();
        while (pending_bytes.size() != 0 || in_valid || level_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // byte driver: holds the item while stalled, idles in random bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            rx_byte  <= '0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                take_byte(rx_byte);
                bytes_taken++;
            end
            // free to change the offer only once the current item is gone
            if (!in_valid || !in_stall)
            begin
                if (send_gap == 0 && idle_on && $urandom_range(0, 11) == 0)
                    send_gap = $urandom_range(1, 18);
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_bytes.size() != 0)
                begin
                    rx_byte  <= pending_bytes.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // reading monitor: checks each accepted result against the oldest owed reading
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            recv_gap = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                seen.status    = status;
                seen.depth     = depth_cm;
                seen.total     = total_liters;
                seen.fill      = fill_percent;
                seen.storage   = storage_liters;
                seen.retention = retention_liters;
                readings++;
                if (level_q.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("unexpected reading: status %0d depth %0d total %0d fill %0d",
                                 seen.status, seen.depth, seen.total, seen.fill);
                end
                else
                begin
                    wanted = level_q.pop_front();
                    if (seen.status !== wanted.status || seen.depth !== wanted.depth
                        || seen.total !== wanted.total || seen.fill !== wanted.fill
                        || seen.storage !== wanted.storage
                        || seen.retention !== wanted.retention)
                    begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                        begin
                            $display("reading %0d mismatch at %0t", readings, $realtime);
                            $display("  want status %0d depth %0d total %0d fill %0d stor %0d ret %0d",
                                     wanted.status, wanted.depth, wanted.total, wanted.fill,
                                     wanted.storage, wanted.retention);
                            $display("  got  status %0d depth %0d total %0d fill %0d stor %0d ret %0d",
                                     seen.status, seen.depth, seen.total, seen.fill,
                                     seen.storage, seen.retention);
                        end
                    end
                end
            end
            // random stall bursts, plus the long hold-off when it is running
            if (recv_gap == 0 && idle_on && $urandom_range(0, 11) == 0)
                recv_gap = $urandom_range(1, 18);
            else if (recv_gap > 0)
                recv_gap--;
            out_stall <= long_hold || recv_gap > 0;
        end
    end

    // long hold-off: the receiver stops for a fixed stretch while bytes keep coming
    initial
    begin
        wait (hold_go);
        long_hold = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        long_hold = 1'b0;
    end

    // watchdog: any handshake on any channel counts as progress
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
            begin
                quiet++;
                if (quiet >= WATCHDOG_LIMIT)
                begin
                    $display("watchdog: no handshake for %0d cycles, %0d readings owed",
                             quiet, level_q.size());
                    $display("ultrasonic_tank_level_frame test failed");
                    $finish;
                end
            end
        end
    end

    // stimulus sequence
    initial
    begin
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // directed frames under the reset settings (200 cm, no offset, 1000 l, 500 l)
        pending_bytes.push_back(8'h00);     // line noise while hunting is dropped
        pending_bytes.push_back(8'h7E);
        pending_bytes.push_back(8'h81);
        push_frame(16'd0, 1'b0);            // no distance: depth exactly full, retention
        push_frame(16'hFFFF, 1'b0);         // header value as data, depth clamps to empty
        push_frame(16'd1000, 1'b1);         // wrong checksum
        push_frame(16'd256, 1'b0);          // checksum wraps to zero
        push_frame(16'd1505, 1'b0);         // mid depth, all of it storage
        wait_drained();

        // zero max depth, with the upper data bits set so the write masks to zero
        set_config(20'hFFC00, 20'h003FF, 20'hFFFFF, 20'h00000);
        repeat (8) add_random_frame();
        wait_drained();

        // largest tank and volumes, masking on the depth writes again
        set_config(20'hFFFFF, 20'h00000, 20'hFFFFF, 20'hFFFFF);
        repeat (10) add_random_frame();
        wait_drained();

        // one centimetre tank with the highest mount and no volume
        set_config(20'h00001, 20'hFFFFF, 20'h00000, 20'h00000);
        repeat (8) add_random_frame();
        wait_drained();

        // random settings; the third phase also runs the long hold-off
        for (int p = 0; p < 6; p++)
        begin
            random_config();
            repeat (25) add_random_frame();
            if (p == 2)
                hold_go = 1'b1;
            wait_drained();
        end

        // closing phase at full rate on both sides
        idle_on = 1'b0;
        random_config();
        repeat (20) add_random_frame();
        wait_drained();

        $display("run covered %0d bytes: %0d good frames, %0d bad checksums, %0d readings",
                 bytes_taken, good_frames, bad_frames, readings);
        $display("%0d register writes across zero, one and full-scale tanks; %0d mismatches",
                 cfg_writes, errors);
        if (errors == 0)
            $display("ultrasonic_tank_level_frame test passed");
        else
            $display("ultrasonic_tank_level_frame test failed");
        $finish;
    end

endmodule

### sim.f
src/utlf_pkg.sv
src/ultrasonic_tank_level_frame.sv
verif/tb_ultrasonic_tank_level_frame.sv
